/* rtl/ufsm_pkg.sv */
// Shared constants, types and helpers for the free-space masker.
package ufsm_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(CELLS);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int XW         = $clog2(MAX_WIDTH);
  localparam int YW         = $clog2(MAX_HEIGHT);
  localparam int PIX_W      = 24;
  localparam int MARK_W     = 2;
  localparam int STK_W      = XW + YW;

  localparam int MM_W   = 21;
  localparam int RES_W  = 10;
  localparam int SIZE_W = 9;
  localparam int DIV_W  = MM_W + 1;

  // mark bits
  localparam int MARK_FREE    = 0;
  localparam int MARK_REACHED = 1;

  // register indexes
  localparam logic [2:0] REG_ROBOT_X = 3'd0;
  localparam logic [2:0] REG_ROBOT_Y = 3'd1;
  localparam logic [2:0] REG_MAP_X0  = 3'd2;
  localparam logic [2:0] REG_MAP_Y0  = 3'd3;
  localparam logic [2:0] REG_RES     = 3'd4;
  localparam logic [2:0] REG_WIDTH   = 3'd5;
  localparam logic [2:0] REG_HEIGHT  = 3'd6;

  typedef struct packed {
    logic signed [MM_W-1:0] robot_x;
    logic signed [MM_W-1:0] robot_y;
    logic signed [MM_W-1:0] map_x0;
    logic signed [MM_W-1:0] map_y0;
    logic [RES_W-1:0]       res;
    logic [SIZE_W-1:0]      width;
    logic [SIZE_W-1:0]      height;
  } cfg_t;

  function automatic logic is_free(input logic [PIX_W-1:0] p);
    is_free = (p == {3{8'd254}}) || (p == {3{8'd255}});
  endfunction

endpackage

/* rtl/ufsm_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module ufsm_ram #(
  parameter int DW = 8,
  parameter int AW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/ufsm_div.sv */
// Restoring divider, one quotient bit per cycle, for the seed position.
module ufsm_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [ufsm_pkg::DIV_W-1:0]   dividend,
  input  logic [ufsm_pkg::RES_W-1:0]   divisor,
  output logic                         done,
  output logic [ufsm_pkg::DIV_W-1:0]   quotient
);

  localparam int CW = $clog2(ufsm_pkg::DIV_W + 1);

  logic [ufsm_pkg::RES_W-1:0] rem;
  logic [ufsm_pkg::RES_W-1:0] dsr;
  logic [CW-1:0]              cnt;
  logic                       busy;
  logic [ufsm_pkg::RES_W:0]   rem_s;
  logic                       ge;

  assign rem_s = {rem, quotient[ufsm_pkg::DIV_W-1]};
  assign ge    = rem_s >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        rem      <= '0;
        dsr      <= (divisor == '0) ? ufsm_pkg::RES_W'(1) : divisor;
        quotient <= dividend;
      end else if (busy) begin
        // dividend shifts out the top while quotient bits shift in
        rem      <= ge ? ufsm_pkg::RES_W'(rem_s - {1'b0, dsr})
                       : rem_s[ufsm_pkg::RES_W-1:0];
        quotient <= {quotient[ufsm_pkg::DIV_W-2:0], ge};
        cnt      <= cnt + CW'(1);
        if (cnt == CW'(ufsm_pkg::DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/ufsm_cfg.sv */
// APB register file for position, resolution and map size.
module ufsm_cfg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output ufsm_pkg::cfg_t       cfg
);

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.robot_x <= '0;
      cfg.robot_y <= '0;
      cfg.map_x0  <= '0;
      cfg.map_y0  <= '0;
      cfg.res     <= ufsm_pkg::RES_W'(50);
      cfg.width   <= ufsm_pkg::SIZE_W'(256);
      cfg.height  <= ufsm_pkg::SIZE_W'(256);
    end else if (wr) begin
      unique case (idx)
        ufsm_pkg::REG_ROBOT_X: cfg.robot_x <= pwdata[ufsm_pkg::MM_W-1:0];
        ufsm_pkg::REG_ROBOT_Y: cfg.robot_y <= pwdata[ufsm_pkg::MM_W-1:0];
        ufsm_pkg::REG_MAP_X0:  cfg.map_x0  <= pwdata[ufsm_pkg::MM_W-1:0];
        ufsm_pkg::REG_MAP_Y0:  cfg.map_y0  <= pwdata[ufsm_pkg::MM_W-1:0];
        ufsm_pkg::REG_RES:     cfg.res     <= pwdata[ufsm_pkg::RES_W-1:0];
        ufsm_pkg::REG_WIDTH:   cfg.width   <= pwdata[ufsm_pkg::SIZE_W-1:0];
        ufsm_pkg::REG_HEIGHT:  cfg.height  <= pwdata[ufsm_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ufsm_pkg::REG_ROBOT_X: prdata = 32'(cfg.robot_x);
      ufsm_pkg::REG_ROBOT_Y: prdata = 32'(cfg.robot_y);
      ufsm_pkg::REG_MAP_X0:  prdata = 32'(cfg.map_x0);
      ufsm_pkg::REG_MAP_Y0:  prdata = 32'(cfg.map_y0);
      ufsm_pkg::REG_RES:     prdata = 32'(cfg.res);
      ufsm_pkg::REG_WIDTH:   prdata = 32'(cfg.width);
      ufsm_pkg::REG_HEIGHT:  prdata = 32'(cfg.height);
      default:               prdata = '0;
    endcase
  end

endmodule

/* rtl/unreachable_free_space_masker.sv */
// Top level: map store, flood fill sequencer and stream/config ports.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------
//  in       | in_valid/in_stall  | func, chan_zero/one/two, load_last
//  out      | out_valid/out_stall| out_chan_zero/one/two, read_last
//  cfg      | APB psel/penable   | paddr, pwdata, prdata
//
// A load beat is written as it is accepted; a read beat waits in S_RD for the
// registered pixel data and a free output. A load with load_last starts the
// fill: two seed divisions, a mark pass over the map, a stack walk that probes
// popped cells' neighbors, and a final pass that blanks unreached free pixels.
// in_stall stays high for the whole fill. Reset is synchronous; memories are
// not cleared, the mark pass rebuilds the mark store for every fill.
module unreachable_free_space_masker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [7:0]  chan_zero,
  input  logic [7:0]  chan_one,
  input  logic [7:0]  chan_two,
  input  logic        load_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_chan_zero,
  output logic [7:0]  out_chan_one,
  output logic [7:0]  out_chan_two,
  output logic        read_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = ufsm_pkg::ADDR_W;
  localparam int CW = ufsm_pkg::CNT_W;
  localparam int XW = ufsm_pkg::XW;
  localparam int YW = ufsm_pkg::YW;
  localparam int QW = ufsm_pkg::DIV_W + 1;
  localparam int IW = XW + YW + 1;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_RD      = 5'd1;
  localparam logic [4:0] S_DXS     = 5'd2;
  localparam logic [4:0] S_DXW     = 5'd3;
  localparam logic [4:0] S_DYS     = 5'd4;
  localparam logic [4:0] S_DYW     = 5'd5;
  localparam logic [4:0] S_SEED    = 5'd6;
  localparam logic [4:0] S_CLR     = 5'd7;
  localparam logic [4:0] S_CLR_END = 5'd8;
  localparam logic [4:0] S_VMUL    = 5'd9;
  localparam logic [4:0] S_VRD     = 5'd10;
  localparam logic [4:0] S_VCHK    = 5'd11;
  localparam logic [4:0] S_POP     = 5'd12;
  localparam logic [4:0] S_POPW    = 5'd13;
  localparam logic [4:0] S_NB      = 5'd14;
  localparam logic [4:0] S_FIN     = 5'd15;
  localparam logic [4:0] S_FIN_END = 5'd16;

  ufsm_pkg::cfg_t cfg;

  logic [4:0]    state;
  logic [CW-1:0] cnt;
  logic          pend;
  logic [AW-1:0] pend_addr;
  logic [XW-1:0] cur_x, nx;
  logic [YW-1:0] cur_y, ny;
  logic [AW-1:0] tgt;
  logic [2:0]    nb;
  logic          seeding;
  logic [CW-1:0] sp;
  logic [AW-1:0] load_pos, read_pos;
  logic          last_r;
  logic signed [QW-1:0] qx, qy;

  // effective sizes
  logic [XW:0]   w_eff;
  logic [YW:0]   h_eff;
  logic [IW-1:0] total_full;
  logic [CW-1:0] total;
  logic [AW-1:0] load_eff, read_eff;
  logic [CW-1:0] load_inc, read_inc;

  always_comb begin
    if (cfg.width == '0)                               w_eff = (XW+1)'(1);
    else if (cfg.width > ufsm_pkg::SIZE_W'(ufsm_pkg::MAX_WIDTH))
                                                       w_eff = (XW+1)'(ufsm_pkg::MAX_WIDTH);
    else                                               w_eff = cfg.width[XW:0];
    if (cfg.height == '0)                              h_eff = (YW+1)'(1);
    else if (cfg.height > ufsm_pkg::SIZE_W'(ufsm_pkg::MAX_HEIGHT))
                                                       h_eff = (YW+1)'(ufsm_pkg::MAX_HEIGHT);
    else                                               h_eff = cfg.height[YW:0];
  end

  assign total_full = IW'(w_eff) * IW'(h_eff);
  assign total      = total_full[CW-1:0];
  assign load_eff   = ({1'b0, load_pos} >= total) ? '0 : load_pos;
  assign read_eff   = ({1'b0, read_pos} >= total) ? '0 : read_pos;
  assign load_inc   = {1'b0, load_eff} + CW'(1);
  assign read_inc   = {1'b0, read_eff} + CW'(1);

  // seed offsets
  logic signed [ufsm_pkg::DIV_W-1:0] dx, dy;
  logic [ufsm_pkg::DIV_W-1:0]        dx_mag, dy_mag;
  logic                              div_start, div_done;
  logic [ufsm_pkg::DIV_W-1:0]        div_dvd, div_q;
  logic signed [QW-1:0]              q_pos;

  assign dx     = {cfg.robot_x[ufsm_pkg::MM_W-1], cfg.robot_x}
                - {cfg.map_x0[ufsm_pkg::MM_W-1], cfg.map_x0};
  assign dy     = {cfg.robot_y[ufsm_pkg::MM_W-1], cfg.robot_y}
                - {cfg.map_y0[ufsm_pkg::MM_W-1], cfg.map_y0};
  assign dx_mag = dx[ufsm_pkg::DIV_W-1] ? ufsm_pkg::DIV_W'(-dx) : dx;
  assign dy_mag = dy[ufsm_pkg::DIV_W-1] ? ufsm_pkg::DIV_W'(-dy) : dy;
  assign div_dvd = (state == S_DXS) ? dx_mag : dy_mag;
  assign q_pos   = $signed({1'b0, div_q});

  ufsm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (cfg.res),
    .done     (div_done),
    .quotient (div_q)
  );

  ufsm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // seed clamp
  logic signed [QW-1:0] wm1;
  logic signed [QW:0]   ty, hm1;
  logic [XW-1:0]        seed_x;
  logic [YW-1:0]        seed_y;

  assign wm1 = $signed(QW'(w_eff)) - QW'(1);
  assign hm1 = $signed((QW+1)'(h_eff)) - (QW+1)'(1);
  assign ty  = hm1 - {qy[QW-1], qy};

  always_comb begin
    if (qx < 0)        seed_x = '0;
    else if (qx > wm1) seed_x = wm1[XW-1:0];
    else               seed_x = qx[XW-1:0];
    if (ty < 0)                      seed_y = '0;
    else if (ty > hm1)               seed_y = hm1[YW-1:0];
    else                             seed_y = ty[YW-1:0];
  end

  // neighbor index
  logic [IW-1:0] idx_full;
  assign idx_full = IW'(ny) * IW'(w_eff) + IW'(nx);

  // memories
  logic                          pix_we, pix_re;
  logic [AW-1:0]                 pix_waddr, pix_raddr;
  logic [ufsm_pkg::PIX_W-1:0]    pix_wdata, pix_rdata;
  logic                          mark_we, mark_re;
  logic [AW-1:0]                 mark_waddr, mark_raddr;
  logic [ufsm_pkg::MARK_W-1:0]   mark_wdata, mark_rdata;
  logic                          stk_we, stk_re;
  logic [AW-1:0]                 stk_waddr, stk_raddr;
  logic [ufsm_pkg::STK_W-1:0]    stk_wdata, stk_rdata;
  logic [CW-1:0]                 sp_m1;
  logic                          in_acc, unreached, can_push;

  assign in_acc    = in_valid && (state == S_IDLE);
  assign in_stall  = (state != S_IDLE);
  assign sp_m1     = sp - CW'(1);
  assign unreached = mark_rdata[ufsm_pkg::MARK_FREE] && !mark_rdata[ufsm_pkg::MARK_REACHED];
  assign can_push  = sp < CW'(ufsm_pkg::CELLS);

  always_comb begin
    pix_we     = 1'b0;
    pix_waddr  = load_eff;
    pix_wdata  = {chan_two, chan_one, chan_zero};
    pix_re     = 1'b0;
    pix_raddr  = cnt[AW-1:0];
    mark_we    = 1'b0;
    mark_waddr = pend_addr;
    mark_wdata = '0;
    mark_re    = 1'b0;
    mark_raddr = cnt[AW-1:0];
    stk_we     = 1'b0;
    stk_waddr  = sp[AW-1:0];
    stk_wdata  = {ny, nx};
    stk_re     = 1'b0;
    stk_raddr  = sp_m1[AW-1:0];
    div_start  = (state == S_DXS) || (state == S_DYS);
    unique case (state)
      S_IDLE: begin
        if (in_acc && !func) pix_we = 1'b1;
        if (in_acc && func) begin
          pix_re    = 1'b1;
          pix_raddr = read_eff;
        end
      end
      S_CLR, S_CLR_END: begin
        pix_re = (state == S_CLR);
        if (pend) begin
          mark_we    = 1'b1;
          mark_wdata = {1'b0, ufsm_pkg::is_free(pix_rdata)};
        end
      end
      S_VRD: begin
        mark_re    = 1'b1;
        mark_raddr = tgt;
      end
      S_VCHK: begin
        if (unreached) begin
          mark_we    = 1'b1;
          mark_waddr = tgt;
          mark_wdata = 2'b11;
          stk_we     = can_push;
        end
      end
      S_POP: begin
        stk_re = (sp != '0);
      end
      S_FIN, S_FIN_END: begin
        pix_re  = (state == S_FIN);
        mark_re = (state == S_FIN);
        if (pend && unreached) begin
          pix_we    = 1'b1;
          pix_waddr = pend_addr;
          pix_wdata = '0;
        end
      end
      default: ;
    endcase
  end

  ufsm_ram #(.DW(ufsm_pkg::PIX_W), .AW(AW)) u_pix (
    .clk (clk), .we (pix_we), .waddr (pix_waddr), .wdata (pix_wdata),
    .re (pix_re), .raddr (pix_raddr), .rdata (pix_rdata)
  );

  ufsm_ram #(.DW(ufsm_pkg::MARK_W), .AW(AW)) u_mark (
    .clk (clk), .we (mark_we), .waddr (mark_waddr), .wdata (mark_wdata),
    .re (mark_re), .raddr (mark_raddr), .rdata (mark_rdata)
  );

  ufsm_ram #(.DW(ufsm_pkg::STK_W), .AW(AW)) u_stk (
    .clk (clk), .we (stk_we), .waddr (stk_waddr), .wdata (stk_wdata),
    .re (stk_re), .raddr (stk_raddr), .rdata (stk_rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      load_pos  <= '0;
      read_pos  <= '0;
      sp        <= '0;
      pend      <= 1'b0;
      seeding   <= 1'b0;
      out_valid <= 1'b0;
      cnt       <= '0;
      nb        <= '0;
    end else begin
      // the read state reloads the output itself when it fires
      if (out_valid && !out_stall && state != S_RD) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_acc && !func) begin
            load_pos <= (load_inc >= total) ? '0 : load_inc[AW-1:0];
            if (load_last) begin
              sp    <= '0;
              state <= S_DXS;
            end
          end else if (in_acc) begin
            last_r   <= (read_inc >= total);
            read_pos <= (read_inc >= total) ? '0 : read_inc[AW-1:0];
            state    <= S_RD;
          end
        end
        S_RD: begin
          if (!out_valid || !out_stall) begin
            out_chan_zero <= pix_rdata[7:0];
            out_chan_one  <= pix_rdata[15:8];
            out_chan_two  <= pix_rdata[23:16];
            read_last     <= last_r;
            out_valid     <= 1'b1;
            state         <= S_IDLE;
          end
        end
        S_DXS: state <= S_DXW;
        S_DXW: begin
          if (div_done) begin
            qx    <= dx[ufsm_pkg::DIV_W-1] ? -q_pos : q_pos;
            state <= S_DYS;
          end
        end
        S_DYS: state <= S_DYW;
        S_DYW: begin
          if (div_done) begin
            qy    <= dy[ufsm_pkg::DIV_W-1] ? -q_pos : q_pos;
            state <= S_SEED;
          end
        end
        S_SEED: begin
          nx    <= seed_x;
          ny    <= seed_y;
          cnt   <= '0;
          pend  <= 1'b0;
          state <= S_CLR;
        end
        S_CLR: begin
          pend      <= 1'b1;
          pend_addr <= cnt[AW-1:0];
          if (cnt == total - CW'(1)) state <= S_CLR_END;
          else                       cnt   <= cnt + CW'(1);
        end
        S_CLR_END: begin
          pend    <= 1'b0;
          seeding <= 1'b1;
          state   <= S_VMUL;
        end
        S_VMUL: begin
          tgt   <= idx_full[AW-1:0];
          state <= S_VRD;
        end
        S_VRD: state <= S_VCHK;
        S_VCHK: begin
          if (unreached && can_push) sp <= sp + CW'(1);
          if (seeding) begin
            seeding <= 1'b0;
            state   <= S_POP;
          end else begin
            nb    <= nb + 3'd1;
            state <= S_NB;
          end
        end
        S_POP: begin
          if (sp == '0) begin
            cnt   <= '0;
            pend  <= 1'b0;
            state <= S_FIN;
          end else begin
            sp    <= sp_m1;
            state <= S_POPW;
          end
        end
        S_POPW: begin
          {cur_y, cur_x} <= stk_rdata;
          nb             <= '0;
          state          <= S_NB;
        end
        S_NB: begin
          priority if (nb == 3'd4) begin
            state <= S_POP;
          end else begin
            unique case (nb[1:0])
              2'd0: begin
                if (cur_x != '0) begin
                  nx <= cur_x - XW'(1); ny <= cur_y; state <= S_VMUL;
                end else nb <= nb + 3'd1;
              end
              2'd1: begin
                if ((XW+1)'(cur_x) + (XW+1)'(1) < w_eff) begin
                  nx <= cur_x + XW'(1); ny <= cur_y; state <= S_VMUL;
                end else nb <= nb + 3'd1;
              end
              2'd2: begin
                if (cur_y != '0) begin
                  nx <= cur_x; ny <= cur_y - YW'(1); state <= S_VMUL;
                end else nb <= nb + 3'd1;
              end
              default: begin
                if ((YW+1)'(cur_y) + (YW+1)'(1) < h_eff) begin
                  nx <= cur_x; ny <= cur_y + YW'(1); state <= S_VMUL;
                end else nb <= nb + 3'd1;
              end
            endcase
          end
        end
        S_FIN: begin
          pend      <= 1'b1;
          pend_addr <= cnt[AW-1:0];
          if (cnt == total - CW'(1)) state <= S_FIN_END;
          else                       cnt   <= cnt + CW'(1);
        end
        S_FIN_END: begin
          pend     <= 1'b0;
          load_pos <= '0;
          read_pos <= '0;
          state    <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // stack never grows past the map
  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= CW'(ufsm_pkg::CELLS))
    else $error("fill stack overflow");

  // a new result beat only comes out of the read state
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_RD)
    else $error("result beat without a read");

  // end of a fill rewinds both stream positions
  a_fin_rewind: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN_END |=> load_pos == '0 && read_pos == '0)
    else $error("positions not rewound after fill");

  // the stack is empty whenever the blanking pass runs
  a_fin_empty: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN |-> sp == '0)
    else $error("blanking pass with pending stack entries");

endmodule

/* test/tb_unreachable_free_space_masker.sv */
// Testbench for the free-space masker: random maps, flood fill prediction, APB setup.
module tb_unreachable_free_space_masker;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic LOAD = 1'b0;
  localparam logic READ = 1'b1;

  typedef struct {
    logic       func;
    logic [7:0] c0, c1, c2;
    logic       last;
  } beat_t;

  typedef struct {
    logic [7:0] c0, c1, c2;
    logic       last;
  } pixel_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_stall, func = 0, load_last = 0;
  logic [7:0] chan_zero = 0, chan_one = 0, chan_two = 0;
  logic out_valid, out_stall = 0, read_last;
  logic [7:0] out_chan_zero, out_chan_one, out_chan_two;
  logic psel = 0, penable = 0, pwrite = 0, pready;
  logic [4:0] paddr = 0;
  logic [31:0] pwdata = 0, prdata;

  unreachable_free_space_masker dut (.*);

  initial forever #5 clk = ~clk;

  beat_t  pend_q[$];
  pixel_t pixel_exp_q[$];
  int     errors = 0;
  bit     calm = 0;
  int     beats_sent = 0;

  // map shadow
  longint rob_x, rob_y, org_x, org_y;
  int unsigned res_reg, width_reg, height_reg;
  bit [23:0] map_mem [ufsm_pkg::CELLS];
  bit [1:0]  mark_mem [ufsm_pkg::CELLS];
  int unsigned load_pos, read_pos;

  function automatic int unsigned map_w();
    if (width_reg == 0) return 1;
    return width_reg > ufsm_pkg::MAX_WIDTH ? ufsm_pkg::MAX_WIDTH : width_reg;
  endfunction

  function automatic int unsigned map_h();
    if (height_reg == 0) return 1;
    return height_reg > ufsm_pkg::MAX_HEIGHT ? ufsm_pkg::MAX_HEIGHT : height_reg;
  endfunction

  function automatic bit open_cell(bit [23:0] p);
    return p == 24'hFEFEFE || p == 24'hFFFFFF;
  endfunction

  function automatic void flood_and_mask();
    int unsigned w, h, total, seed, idx, x, y, nb;
    longint res, px, py;
    int unsigned stack[$];
    w = map_w();
    h = map_h();
    total = w * h;
    res = (res_reg == 0) ? 1 : res_reg;
    px = (rob_x - org_x) / res;
    py = longint'(h) - (rob_y - org_y) / res - 1;
    if (px < 0) px = 0;
    if (px > w - 1) px = w - 1;
    if (py < 0) py = 0;
    if (py > h - 1) py = h - 1;
    seed = int'(py) * w + int'(px);
    for (int i = 0; i < total; i++) mark_mem[i] = {1'b0, open_cell(map_mem[i])};
    if (mark_mem[seed] == 2'b01) begin
      mark_mem[seed] = 2'b11;
      stack.push_back(seed);
    end
    while (stack.size() > 0) begin
      idx = stack.pop_back();
      x = idx % w;
      y = idx / w;
      for (int d = 0; d < 4; d++) begin
        nb = total;
        case (d)
          0: if (x > 0) nb = idx - 1;
          1: if (x + 1 < w) nb = idx + 1;
          2: if (y > 0) nb = idx - w;
          3: if (y + 1 < h) nb = idx + w;
          default: ;
        endcase
        if (nb < total && mark_mem[nb] == 2'b01) begin
          mark_mem[nb] = 2'b11;
          stack.push_back(nb);
        end
      end
    end
    for (int i = 0; i < total; i++) if (mark_mem[i] == 2'b01) map_mem[i] = '0;
    load_pos = 0;
    read_pos = 0;
  endfunction

  function automatic void predict_beat(beat_t b);
    int unsigned total;
    pixel_t e;
    total = map_w() * map_h();
    if (b.func == LOAD) begin
      if (load_pos >= total) load_pos = 0;
      map_mem[load_pos] = {b.c2, b.c1, b.c0};
      load_pos = (load_pos + 1 >= total) ? 0 : load_pos + 1;
      if (b.last) flood_and_mask();
    end else begin
      if (read_pos >= total) read_pos = 0;
      {e.c2, e.c1, e.c0} = map_mem[read_pos];
      e.last = (read_pos + 1 >= total);
      read_pos = e.last ? 0 : read_pos + 1;
      pixel_exp_q.push_back(e);
    end
  endfunction

  // sender
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) predict_beat('{func, chan_zero, chan_one, chan_two, load_last});
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 0;
      end else if (pend_q.size() > 0) begin
        beat_t b;
        b = pend_q.pop_front();
        func <= b.func;
        chan_zero <= b.c0;
        chan_one <= b.c1;
        chan_two <= b.c2;
        load_last <= b.last;
        in_valid <= 1;
        if (!calm && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 12);
      end else begin
        in_valid <= 0;
      end
    end
  end

  // receiver and checker
  int recv_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pixel_exp_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected pixel beat %h %h %h last %b", $time,
                   out_chan_zero, out_chan_one, out_chan_two, read_last);
        end else begin
          pixel_t e;
          e = pixel_exp_q.pop_front();
          if (e.c0 !== out_chan_zero || e.c1 !== out_chan_one ||
              e.c2 !== out_chan_two || e.last !== read_last) begin
            errors++;
            $display("%0t: pixel mismatch expected %h %h %h last %b, got %h %h %h last %b",
                     $time, e.c0, e.c1, e.c2, e.last,
                     out_chan_zero, out_chan_one, out_chan_two, read_last);
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        recv_gap = $urandom_range(0, 11);
        out_stall <= 1;
      end else begin
        out_stall <= 0;
      end
    end
  end

  task automatic reg_write(logic [2:0] idx, longint val);
    @(posedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= 32'(val);
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    case (idx)
      ufsm_pkg::REG_ROBOT_X: rob_x = longint'(signed'(21'(val)));
      ufsm_pkg::REG_ROBOT_Y: rob_y = longint'(signed'(21'(val)));
      ufsm_pkg::REG_MAP_X0:  org_x = longint'(signed'(21'(val)));
      ufsm_pkg::REG_MAP_Y0:  org_y = longint'(signed'(21'(val)));
      ufsm_pkg::REG_RES:     res_reg = 32'(val & 10'h3FF);
      ufsm_pkg::REG_WIDTH:   width_reg = 32'(val & 9'h1FF);
      ufsm_pkg::REG_HEIGHT:  height_reg = 32'(val & 9'h1FF);
      default: ;
    endcase
  endtask

  // wait for every read beat and let a possible fill finish
  task automatic drain();
    wait (pend_q.size() == 0 && pixel_exp_q.size() == 0);
    @(posedge clk);
    wait (!in_valid);
    repeat (64 + 24 * map_w() * map_h()) @(posedge clk);
    wait (!in_stall);
  endtask

  function automatic beat_t map_pixel(bit last);
    beat_t b;
    int unsigned r, v;
    r = $urandom_range(0, 9);
    b.func = LOAD;
    b.last = last;
    v = $urandom_range(0, 1) ? 8'd255 : 8'd254;
    {b.c0, b.c1, b.c2} = {3{8'(v)}};
    if (r >= 6) {b.c0, b.c1, b.c2} = 24'($urandom);
    if (r == 9) case ($urandom_range(0, 2))
      0: b.c0 = 8'($urandom);
      1: b.c1 = 8'($urandom);
      2: b.c2 = 8'($urandom);
      default: ;
    endcase
    return b;
  endfunction

  // one map: optional size/seed setup, load (full or partial), then reads
  task automatic run_map(int w, int h, longint rx, longint ry, longint ox, longint oy,
                         int res, bit setup, int loads, bit fill, int reads);
    beat_t rd;
    if (setup) begin
      reg_write(ufsm_pkg::REG_WIDTH, w);
      reg_write(ufsm_pkg::REG_HEIGHT, h);
      reg_write(ufsm_pkg::REG_ROBOT_X, rx);
      reg_write(ufsm_pkg::REG_ROBOT_Y, ry);
      reg_write(ufsm_pkg::REG_MAP_X0, ox);
      reg_write(ufsm_pkg::REG_MAP_Y0, oy);
      reg_write(ufsm_pkg::REG_RES, res);
    end
    for (int i = 0; i < loads; i++) pend_q.push_back(map_pixel(fill && i == loads - 1));
    rd = '{READ, 8'h00, 8'h00, 8'h00, 1'b0};
    for (int i = 0; i < reads; i++) begin
      rd.c0 = 8'($urandom);
      rd.c1 = 8'($urandom);
      rd.c2 = 8'($urandom);
      rd.last = 1'($urandom);
      pend_q.push_back(rd);
    end
    beats_sent += loads + reads;
    drain();
  endtask

  task automatic random_map();
    int w, h, res, tot;
    longint ox, oy, rx, ry;
    case ($urandom_range(0, 19))
      0: begin w = $urandom_range(13, 32); h = $urandom_range(1, 2); end
      1: begin w = $urandom_range(1, 2); h = $urandom_range(13, 32); end
      default: begin w = $urandom_range(1, 12); h = $urandom_range(1, 12); end
    endcase
    res = $urandom_range(1, 1000);
    ox = longint'($urandom_range(0, 1200000)) - 600000;
    oy = longint'($urandom_range(0, 1200000)) - 600000;
    rx = ox + longint'($urandom_range(0, w * res + 2 * res)) - res;
    ry = oy + longint'($urandom_range(0, h * res + 2 * res)) - res;
    if ($urandom_range(0, 7) == 0) rx = longint'($urandom_range(0, 2000000)) - 1000000;
    tot = w * h;
    run_map(w, h, rx, ry, ox, oy, res, 1, tot, $urandom_range(0, 9) != 0,
            $urandom_range(0, tot + 3));
    // partial reload over already written cells, then fill again
    if ($urandom_range(0, 3) == 0)
      run_map(w, h, 0, 0, 0, 0, 0, 0, $urandom_range(1, tot), 1, $urandom_range(0, tot));
  endtask

  initial begin
    rob_x = 0; rob_y = 0; org_x = 0; org_y = 0;
    res_reg = 50; width_reg = 256; height_reg = 256;
    load_pos = 0; read_pos = 0;
    repeat (8) @(posedge clk);
    rst <= 0;
    // zero sizes act as 1x1, zero resolution as 1
    run_map(0, 0, 0, 0, 0, 0, 0, 1, 1, 1, 3);
    // wide row, clamped width, far negative robot
    run_map(511, 1, -1000000, 1000000, 1000000, -1000000, 1000, 1, 256, 1, 4);
    // tall column, robot far positive
    run_map(1, 256, 1000000, -1000000, -1000000, 1000000, 1, 1, 256, 1, 3);
    // read without a fill
    run_map(3, 3, 0, 0, 0, 0, 50, 1, 9, 0, 10);
    pend_q.push_back('{LOAD, 8'h00, 8'h00, 8'h00, 1'b1});
    beats_sent++;
    drain();
    while (beats_sent < 550) random_map();
    calm = 1;
    while (beats_sent < 650) random_map();
    repeat (200) @(posedge clk);
    if (errors == 0 && pixel_exp_q.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #50ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule
